>>> design/wavhp_pkg.sv
package wavhp_pkg;

  // Subchunk tags as they sit in the gather word (little-endian ASCII)
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [31:0] FMT_BODY_LEN = 32'd16;

  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_BAD_RIFF = 4'd1;
  localparam logic [3:0] ST_FMT_SIZE = 4'd2;
  localparam logic [3:0] ST_FORMAT   = 4'd3;
  localparam logic [3:0] ST_CHANNELS = 4'd4;
  localparam logic [3:0] ST_RATE     = 4'd5;
  localparam logic [3:0] ST_BITS     = 4'd6;
  localparam logic [3:0] ST_NO_FMT   = 4'd7;
  localparam logic [3:0] ST_TRUNC    = 4'd8;

  localparam logic [1:0] REG_FORMAT   = 2'd0;
  localparam logic [1:0] REG_CHANNELS = 2'd1;
  localparam logic [1:0] REG_RATE     = 2'd2;
  localparam logic [1:0] REG_BITS     = 2'd3;

  localparam logic [15:0] RST_FORMAT   = 16'd1;
  localparam logic [15:0] RST_CHANNELS = 16'd1;
  localparam logic [31:0] RST_RATE     = 32'd22050;
  localparam logic [15:0] RST_BITS     = 16'd8;

  typedef enum logic [4:0] {
    PH_RIFF = 5'b00001,
    PH_HDR  = 5'b00010,
    PH_FMT  = 5'b00100,
    PH_SKIP = 5'b01000,
    PH_DONE = 5'b10000
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  cnt;
    logic [31:0] gather;
    logic [31:0] tag;      // holds the first failing status during the fmt body
    logic [31:0] skip;
    logic [31:0] pos;
    logic        fmt_seen;
  } parse_state_t;

  localparam parse_state_t PARSE_RESET = '{
    phase:    PH_RIFF,
    cnt:      4'd0,
    gather:   32'd0,
    tag:      32'd0,
    skip:     32'd0,
    pos:      32'd0,
    fmt_seen: 1'b0
  };

  typedef struct packed {
    logic [15:0] format;
    logic [15:0] channels;
    logic [31:0] rate;
    logic [15:0] bits;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [31:0] data_offset;
    logic [31:0] data_size;
  } result_t;

endpackage

>>> design/wavhp_in_if.sv
interface wavhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output first_byte, output last_byte,
                  input ready);
  modport sink (input valid, input data_byte, input first_byte, input last_byte,
                output ready);
endinterface

>>> design/wavhp_out_if.sv
interface wavhp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [31:0] data_offset;
  logic [31:0] data_size;

  modport source (output valid, output status, output data_offset, output data_size,
                  input ready);
  modport sink (input valid, input status, input data_offset, input data_size,
                output ready);
endinterface

>>> design/wav_header_parser_core.sv
// RIFF/WAVE header parser, one file byte per word on in_chan.
// The status word for the byte that ends the parse is registered into the output stage.
// Throughput: one byte per cycle while skid is empty; the parse step is one registered pass.
// A two-entry output stage (register plus skid) lets input keep flowing while a result waits.
// Synchronous active-low reset: parse restarts at the RIFF tag, config regs return to
// format 1, 1 channel, 22050 Hz, 8 bits.
module wav_header_parser_core (
  input  logic             clk,
  input  logic             rst_n,
  wavhp_in_if.sink         in_chan,
  wavhp_out_if.source      out_chan,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_wdata
);

  wavhp_pkg::cfg_t         cfg_r;
  wavhp_pkg::parse_state_t state_r;
  wavhp_pkg::parse_state_t state_nxt;
  wavhp_pkg::result_t      res;
  wavhp_pkg::result_t      out_r;
  wavhp_pkg::result_t      skid_r;
  logic                    res_valid;
  logic                    out_v_r;
  logic                    skid_v_r;
  logic                    in_fire;
  logic                    out_fire;

  assign in_chan.ready = !skid_v_r;
  assign in_fire       = in_chan.valid && !skid_v_r;
  assign out_fire      = out_v_r && out_chan.ready;

  assign out_chan.valid       = out_v_r;
  assign out_chan.status      = out_r.status;
  assign out_chan.data_offset = out_r.data_offset;
  assign out_chan.data_size   = out_r.data_size;

  wavhp_step u_step (
    .cur        (state_r),
    .cfg        (cfg_r),
    .data_byte  (in_chan.data_byte),
    .first_byte (in_chan.first_byte),
    .last_byte  (in_chan.last_byte),
    .nxt        (state_nxt),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.format   <= wavhp_pkg::RST_FORMAT;
      cfg_r.channels <= wavhp_pkg::RST_CHANNELS;
      cfg_r.rate     <= wavhp_pkg::RST_RATE;
      cfg_r.bits     <= wavhp_pkg::RST_BITS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wavhp_pkg::REG_FORMAT:   cfg_r.format   <= cfg_wdata[15:0];
        wavhp_pkg::REG_CHANNELS: cfg_r.channels <= cfg_wdata[15:0];
        wavhp_pkg::REG_RATE:     cfg_r.rate     <= cfg_wdata;
        wavhp_pkg::REG_BITS:     cfg_r.bits     <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wavhp_pkg::PARSE_RESET;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // output register with skid; input stalls only while the skid entry is full
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_fire) begin
        skid_v_r <= 1'b0;
      end
    end else if (in_fire && res_valid) begin
      if (!out_v_r || out_fire) begin
        out_v_r <= 1'b1;
      end else begin
        skid_v_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_fire) out_r <= skid_r;
    end else if (in_fire && res_valid) begin
      if (!out_v_r || out_fire) out_r <= res;
      else skid_r <= res;
    end
  end

endmodule

>>> design/wavhp_step.sv
module wavhp_step (
  input  wavhp_pkg::parse_state_t cur,
  input  wavhp_pkg::cfg_t         cfg,
  input  logic [7:0]              data_byte,
  input  logic                    first_byte,
  input  logic                    last_byte,
  output wavhp_pkg::parse_state_t nxt,
  output logic                    res_valid,
  output wavhp_pkg::result_t      res
);

  wavhp_pkg::parse_state_t s;
  logic [31:0] gw;
  logic [15:0] half;
  logic [3:0]  cnt;
  logic [31:0] tag;
  logic        emit;

  always_comb begin
    s    = first_byte ? wavhp_pkg::PARSE_RESET : cur;
    nxt  = s;
    res  = '0;
    emit = 1'b0;
    gw   = {data_byte, s.gather[31:8]};
    half = gw[31:16];
    cnt  = s.cnt;
    tag  = s.tag;

    if (s.phase != wavhp_pkg::PH_DONE) begin
      nxt.gather = gw;
      unique case (s.phase)
        wavhp_pkg::PH_RIFF: begin
          if (cnt == 4'd3 && gw != wavhp_pkg::TAG_RIFF) begin
            emit       = 1'b1;
            res.status = wavhp_pkg::ST_BAD_RIFF;
          end else if (cnt == 4'd11) begin
            if (gw != wavhp_pkg::TAG_WAVE) begin
              emit       = 1'b1;
              res.status = wavhp_pkg::ST_BAD_RIFF;
            end else begin
              nxt.phase = wavhp_pkg::PH_HDR;
              cnt       = 4'hF;
            end
          end
        end
        wavhp_pkg::PH_HDR: begin
          if (cnt == 4'd3) begin
            nxt.tag = gw;
          end else if (cnt == 4'd7) begin
            if (s.tag == wavhp_pkg::TAG_FMT) begin
              if (gw != wavhp_pkg::FMT_BODY_LEN) begin
                emit       = 1'b1;
                res.status = wavhp_pkg::ST_FMT_SIZE;
              end else begin
                nxt.phase = wavhp_pkg::PH_FMT;
                nxt.tag   = 32'd0;
                cnt       = 4'hF;
              end
            end else if (s.tag == wavhp_pkg::TAG_DATA) begin
              emit = 1'b1;
              if (s.fmt_seen) begin
                res.status      = wavhp_pkg::ST_OK;
                res.data_offset = s.pos + 32'd1;
                res.data_size   = gw;
              end else begin
                res.status = wavhp_pkg::ST_NO_FMT;
              end
            end else begin
              nxt.skip  = gw;
              nxt.phase = (gw != 32'd0) ? wavhp_pkg::PH_SKIP : wavhp_pkg::PH_HDR;
              cnt       = 4'hF;
            end
          end
        end
        wavhp_pkg::PH_FMT: begin
          // first failing field wins; verdict only after the whole body
          if (tag == 32'd0) begin
            if (cnt == 4'd1 && half != cfg.format)
              tag = {28'd0, wavhp_pkg::ST_FORMAT};
            else if (cnt == 4'd3 && half != cfg.channels)
              tag = {28'd0, wavhp_pkg::ST_CHANNELS};
            else if (cnt == 4'd7 && gw != cfg.rate)
              tag = {28'd0, wavhp_pkg::ST_RATE};
            else if (cnt == 4'd15 && half != cfg.bits)
              tag = {28'd0, wavhp_pkg::ST_BITS};
          end
          if (cnt == 4'd15) begin
            if (tag != 32'd0 && !last_byte) begin
              emit       = 1'b1;
              res.status = tag[3:0];
            end else if (tag == 32'd0) begin
              nxt.fmt_seen = 1'b1;
              nxt.phase    = wavhp_pkg::PH_HDR;
            end
            tag = 32'd0;
          end
          nxt.tag = tag;
        end
        wavhp_pkg::PH_SKIP: begin
          nxt.skip = s.skip - 32'd1;
          if (s.skip == 32'd1) nxt.phase = wavhp_pkg::PH_HDR;
          cnt = 4'hF;
        end
        default: begin
          nxt.phase = wavhp_pkg::PH_DONE;
        end
      endcase

      nxt.cnt = cnt + 4'd1;
      if (!emit && last_byte) begin
        emit       = 1'b1;
        res        = '0;
        res.status = wavhp_pkg::ST_TRUNC;
      end
      nxt.pos = s.pos + 32'd1;
      if (emit) nxt.phase = wavhp_pkg::PH_DONE;
    end
    res_valid = emit;
  end

endmodule
